/* design/uart_fs_pkg.sv */
// Shared action codes and status constants for the UART FIFO status model.
package uart_fs_pkg;

    localparam int ACTION_W = 3;
    localparam int BYTE_W   = 8;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [BYTE_W-1:0]   byte_t;

    localparam action_t ACT_CPU_SEND      = 3'd0;
    localparam action_t ACT_LINE_RECV     = 3'd1;
    localparam action_t ACT_CONSOLE_DRAIN = 3'd2;
    localparam action_t ACT_CPU_READ      = 3'd3;
    localparam action_t ACT_STATUS        = 3'd4;

    localparam byte_t STATUS_RESET   = 8'hFF;
    localparam byte_t STATUS_BASE    = 8'h20;
    localparam byte_t STATUS_TX_DATA = 8'h80;
    localparam byte_t STATUS_RX_DATA = 8'h41;
    localparam byte_t STATUS_CLR_MSK = 8'hDF;
    localparam int    STATUS_TOG_BIT = 5;

endpackage

/* design/uart_fifo_status_model_unit.sv */
// UART register model: transmit and receive FIFOs, data register, line status register.
// Result path: a push, status read or failed pop loads its result word straight into the output
//   register; a successful pop first registers the FIFO memory read data, then loads from it.
// Throughput: one word per cycle while the output is not stalled, except that a successful pop
//   holds off the next input word while its memory read completes.
// Reset: counts, pointers and data register clear, status register goes to 0xFF;
//   FIFO storage is not cleared, as only written entries are ever popped.
module uart_fifo_status_model_unit #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] action,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       done_res,
    output logic [7:0] data_register,
    output logic [7:0] line_status,
    output logic       interrupt_request,
    output logic       console_valid
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(FIFO_DEPTH - 1);

    // FIFO storage: one write port (push) and one registered read port (pop) each
    uart_fs_pkg::byte_t tx_mem [FIFO_DEPTH];
    uart_fs_pkg::byte_t rx_mem [FIFO_DEPTH];
    uart_fs_pkg::byte_t tx_rdata_reg;
    uart_fs_pkg::byte_t rx_rdata_reg;

    logic [CNT_W-1:0] tx_count_reg, tx_count_next;
    logic [CNT_W-1:0] rx_count_reg, rx_count_next;
    logic [PTR_W-1:0] tx_wr_reg, tx_wr_next, tx_rd_reg, tx_rd_next;
    logic [PTR_W-1:0] rx_wr_reg, rx_wr_next, rx_rd_reg, rx_rd_next;
    uart_fs_pkg::byte_t data_reg, data_next;
    uart_fs_pkg::byte_t status_reg, status_next;

    // A successful pop waits here for the memory read data
    logic pop_pending_reg, pop_pending_next;
    logic pop_console_reg, pop_console_next;

    // Output word register
    logic               out_valid_reg, out_valid_next;
    logic               out_done_reg, out_done_next;
    uart_fs_pkg::byte_t out_data_reg, out_data_next;
    uart_fs_pkg::byte_t out_status_reg, out_status_next;
    logic               out_irq_reg, out_irq_next;
    logic               out_cons_reg, out_cons_next;

    logic accept;
    logic tx_full, tx_empty, rx_full, rx_empty;
    logic tx_push, rx_push, tx_pop, rx_pop, stat_rd;
    uart_fs_pkg::byte_t pop_byte;
    uart_fs_pkg::byte_t fresh_status;

    // Hold the input while a pop read is in flight or the output word is stuck
    assign in_stall = pop_pending_reg | (out_valid_reg & out_stall);
    assign accept   = in_valid & ~in_stall;

    assign tx_full  = (tx_count_reg == DEPTH_C);
    assign rx_full  = (rx_count_reg == DEPTH_C);
    assign tx_empty = (tx_count_reg == '0);
    assign rx_empty = (rx_count_reg == '0);

    assign pop_byte = pop_console_reg ? tx_rdata_reg : rx_rdata_reg;

    // Decode the event; pushes to a full FIFO and pops from an empty one do nothing
    always_comb
    begin
        tx_push = 1'b0;
        rx_push = 1'b0;
        tx_pop  = 1'b0;
        rx_pop  = 1'b0;
        stat_rd = 1'b0;
        case (action)
            uart_fs_pkg::ACT_CPU_SEND:      tx_push = accept & ~tx_full;
            uart_fs_pkg::ACT_LINE_RECV:     rx_push = accept & ~rx_full;
            uart_fs_pkg::ACT_CONSOLE_DRAIN: tx_pop  = accept & ~tx_empty;
            uart_fs_pkg::ACT_CPU_READ:      rx_pop  = accept & ~rx_empty;
            uart_fs_pkg::ACT_STATUS:        stat_rd = accept;
            default:
            begin
                tx_push = 1'b0;
            end
        endcase
    end

    // Status read toggles between a freshly built value and that value with bit 5 cleared
    always_comb
    begin
        fresh_status = uart_fs_pkg::STATUS_BASE;
        if (!tx_empty)
            fresh_status = fresh_status | uart_fs_pkg::STATUS_TX_DATA;
        if (!rx_empty)
            fresh_status = fresh_status | uart_fs_pkg::STATUS_RX_DATA;

        status_next = status_reg;
        if (stat_rd)
        begin
            if (!status_reg[uart_fs_pkg::STATUS_TOG_BIT])
                status_next = fresh_status;
            else
                status_next = status_reg & uart_fs_pkg::STATUS_CLR_MSK;
        end
    end

    // Pointers and counts advance at acceptance, so the next word sees them at once
    always_comb
    begin
        tx_wr_next    = tx_wr_reg;
        tx_rd_next    = tx_rd_reg;
        rx_wr_next    = rx_wr_reg;
        rx_rd_next    = rx_rd_reg;
        tx_count_next = tx_count_reg;
        rx_count_next = rx_count_reg;
        if (tx_push)
        begin
            tx_wr_next    = (tx_wr_reg == LAST_C) ? '0 : tx_wr_reg + 1'b1;
            tx_count_next = tx_count_reg + 1'b1;
        end
        if (tx_pop)
        begin
            tx_rd_next    = (tx_rd_reg == LAST_C) ? '0 : tx_rd_reg + 1'b1;
            tx_count_next = tx_count_reg - 1'b1;
        end
        if (rx_push)
        begin
            rx_wr_next    = (rx_wr_reg == LAST_C) ? '0 : rx_wr_reg + 1'b1;
            rx_count_next = rx_count_reg + 1'b1;
        end
        if (rx_pop)
        begin
            rx_rd_next    = (rx_rd_reg == LAST_C) ? '0 : rx_rd_reg + 1'b1;
            rx_count_next = rx_count_reg - 1'b1;
        end
    end

    // Output word: a completed pop loads it from memory data, other events load it directly
    always_comb
    begin
        pop_pending_next = 1'b0;
        pop_console_next = pop_console_reg;
        data_next        = data_reg;
        out_valid_next   = out_valid_reg & out_stall;
        out_done_next    = out_done_reg;
        out_data_next    = out_data_reg;
        out_status_next  = out_status_reg;
        out_irq_next     = out_irq_reg;
        out_cons_next    = out_cons_reg;

        if (pop_pending_reg)
        begin
            data_next       = pop_byte;
            out_valid_next  = 1'b1;
            out_done_next   = 1'b1;
            out_data_next   = pop_byte;
            out_status_next = status_reg;
            out_irq_next    = 1'b0;
            out_cons_next   = pop_console_reg;
        end
        else if (tx_pop || rx_pop)
        begin
            pop_pending_next = 1'b1;
            pop_console_next = tx_pop;
        end
        else if (accept)
        begin
            out_valid_next  = 1'b1;
            out_done_next   = tx_push | rx_push | stat_rd;
            out_data_next   = data_reg;
            out_status_next = status_next;
            out_irq_next    = rx_push;
            out_cons_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tx_push)
            tx_mem[tx_wr_reg] <= data_byte;
        if (tx_pop)
            tx_rdata_reg <= tx_mem[tx_rd_reg];
    end

    always_ff @(posedge clk)
    begin
        if (rx_push)
            rx_mem[rx_wr_reg] <= data_byte;
        if (rx_pop)
            rx_rdata_reg <= rx_mem[rx_rd_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_count_reg    <= '0;
            rx_count_reg    <= '0;
            tx_wr_reg       <= '0;
            tx_rd_reg       <= '0;
            rx_wr_reg       <= '0;
            rx_rd_reg       <= '0;
            data_reg        <= '0;
            status_reg      <= uart_fs_pkg::STATUS_RESET;
            pop_pending_reg <= 1'b0;
            pop_console_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            tx_count_reg    <= tx_count_next;
            rx_count_reg    <= rx_count_next;
            tx_wr_reg       <= tx_wr_next;
            tx_rd_reg       <= tx_rd_next;
            rx_wr_reg       <= rx_wr_next;
            rx_rd_reg       <= rx_rd_next;
            data_reg        <= data_next;
            status_reg      <= status_next;
            pop_pending_reg <= pop_pending_next;
            pop_console_reg <= pop_console_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_done_reg   <= out_done_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_irq_reg    <= out_irq_next;
        out_cons_reg   <= out_cons_next;
    end

    assign out_valid         = out_valid_reg;
    assign done_res          = out_done_reg;
    assign data_register     = out_data_reg;
    assign line_status       = out_status_reg;
    assign interrupt_request = out_irq_reg;
    assign console_valid     = out_cons_reg;

    // A pop in flight never overlaps a waiting output word
    a_pend_excl: assert property (@(posedge clk) disable iff (!rst_n)
        pop_pending_reg |-> !out_valid_reg)
        else $error("pop pending while output word held");

    // Counts never exceed the FIFO depth
    a_tx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tx_count_reg <= DEPTH_C)
        else $error("transmit count overflow");

    a_rx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rx_count_reg <= DEPTH_C)
        else $error("receive count overflow");

    // Every accepted word yields either a pending pop or an output word next cycle
    a_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (out_valid_reg || pop_pending_reg))
        else $error("accepted word produced nothing");

    // A completed pop always leaves a valid output word and updates the data register
    a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
        pop_pending_reg |=> (out_valid_reg && out_done_reg && data_reg == out_data_reg))
        else $error("pop did not complete");

endmodule

/* tb/lsr_scoreboard_pkg.sv */
`timescale 1ns / 100ps
// Line status predictor and result word scoreboard for the UART FIFO status unit.
package lsr_scoreboard_pkg;

    // Action codes the block ignores.
    localparam uart_fs_pkg::action_t ACT_UNUSED_LO = 3'd5;
    localparam uart_fs_pkg::action_t ACT_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic               done;
        uart_fs_pkg::byte_t data;
        uart_fs_pkg::byte_t status;
        logic               irq;
        logic               cons;
    } lsr_word_t;

    class uart_lsr_scoreboard;
        uart_fs_pkg::byte_t tx_bytes[$];
        uart_fs_pkg::byte_t rx_bytes[$];
        uart_fs_pkg::byte_t data_reg;
        uart_fs_pkg::byte_t status_reg;
        lsr_word_t          expected_words[$];
        int                 fifo_depth;
        int                 mismatches;

        function new(int depth);
            fifo_depth = depth;
            data_reg   = '0;
            status_reg = uart_fs_pkg::STATUS_RESET;
            mismatches = 0;
        endfunction

        // Advance the predictor by one accepted input word.
        function void note_word(uart_fs_pkg::action_t act, uart_fs_pkg::byte_t value);
            lsr_word_t w;
            w = '0;
            case (act)
                uart_fs_pkg::ACT_CPU_SEND:
                    if (tx_bytes.size() < fifo_depth)
                    begin
                        tx_bytes.push_back(value);
                        w.done = 1'b1;
                    end
                uart_fs_pkg::ACT_LINE_RECV:
                    if (rx_bytes.size() < fifo_depth)
                    begin
                        rx_bytes.push_back(value);
                        w.done = 1'b1;
                        w.irq  = 1'b1;
                    end
                uart_fs_pkg::ACT_CONSOLE_DRAIN:
                    if (tx_bytes.size() != 0)
                    begin
                        data_reg = tx_bytes.pop_front();
                        w.done   = 1'b1;
                        w.cons   = 1'b1;
                    end
                uart_fs_pkg::ACT_CPU_READ:
                    if (rx_bytes.size() != 0)
                    begin
                        data_reg = rx_bytes.pop_front();
                        w.done   = 1'b1;
                    end
                uart_fs_pkg::ACT_STATUS:
                begin
                    if (!status_reg[uart_fs_pkg::STATUS_TOG_BIT])
                    begin
                        status_reg = uart_fs_pkg::STATUS_BASE;
                        if (tx_bytes.size() != 0)
                            status_reg = status_reg | uart_fs_pkg::STATUS_TX_DATA;
                        if (rx_bytes.size() != 0)
                            status_reg = status_reg | uart_fs_pkg::STATUS_RX_DATA;
                    end
                    else
                        status_reg = status_reg & uart_fs_pkg::STATUS_CLR_MSK;
                    w.done = 1'b1;
                end
                default: ;
            endcase
            w.data   = data_reg;
            w.status = status_reg;
            expected_words.push_back(w);
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // Compare one accepted result word with the oldest expectation.
        task check_word(lsr_word_t got);
            lsr_word_t exp;
            if (expected_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word %h", got));
                return;
            end
            exp = expected_words.pop_front();
            if (got.done !== exp.done || got.data !== exp.data || got.status !== exp.status
                || got.irq !== exp.irq || got.cons !== exp.cons)
                report_mismatch($sformatf(
                    "done %b/%b data %h/%h status %h/%h irq %b/%b cons %b/%b (got/exp)",
                    got.done, exp.done, got.data, exp.data, got.status, exp.status,
                    got.irq, exp.irq, got.cons, exp.cons));
        endtask

        function int words_outstanding();
            return expected_words.size();
        endfunction
    endclass

endpackage

/* tb/tb.sv */
`timescale 1ns / 100ps
// Top-level testbench for the UART FIFO status unit: stimulus, handshakes and run control.
module tb;

    localparam int FIFO_DEPTH   = 16;
    localparam int RANDOM_WORDS = 400;
    localparam int SEG_WORDS    = 40;
    localparam int HOLD_CYCLES  = 120;
    localparam int CYCLE_LIMIT  = 100000;

    // Bias of a stretch of random words: fill one FIFO, empty both, or anything.
    typedef enum int {MIX_FILL_TX, MIX_FILL_RX, MIX_DRAIN, MIX_ANY} mix_e;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    uart_fs_pkg::action_t action;
    uart_fs_pkg::byte_t   data_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic                 done_res;
    uart_fs_pkg::byte_t   data_register;
    uart_fs_pkg::byte_t   line_status;
    logic                 interrupt_request;
    logic                 console_valid;

    lsr_scoreboard_pkg::uart_lsr_scoreboard lsr_sb;
    bit quiet;          // when set, neither side idles
    bit hold_req;       // ask the receiver for one long hold-off
    int cycle_count = 0;

    uart_fifo_status_model_unit #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .data_byte         (data_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .done_res          (done_res),
        .data_register     (data_register),
        .line_status       (line_status),
        .interrupt_request (interrupt_request),
        .console_valid     (console_valid)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: give up long after the slowest legal run would have finished.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Idle cycles for one word on either side; none while the stretch is quiet.
    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic uart_fs_pkg::byte_t draw_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return uart_fs_pkg::byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Pick an action with the weighting of the current stretch; a few unused
    // codes and status reads are sprinkled into every stretch.
    function automatic uart_fs_pkg::action_t pick_action(mix_e mix);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return uart_fs_pkg::action_t'($urandom_range(lsr_scoreboard_pkg::ACT_UNUSED_LO,
                                                         lsr_scoreboard_pkg::ACT_UNUSED_HI));
        if (roll < 15)
            return uart_fs_pkg::ACT_STATUS;
        case (mix)
            MIX_FILL_TX:
                return (roll < 80) ? uart_fs_pkg::ACT_CPU_SEND
                                   : uart_fs_pkg::action_t'($urandom_range(
                                         uart_fs_pkg::ACT_CPU_SEND, uart_fs_pkg::ACT_CPU_READ));
            MIX_FILL_RX:
                return (roll < 80) ? uart_fs_pkg::ACT_LINE_RECV
                                   : uart_fs_pkg::action_t'($urandom_range(
                                         uart_fs_pkg::ACT_CPU_SEND, uart_fs_pkg::ACT_CPU_READ));
            MIX_DRAIN:
                return (roll < 57) ? uart_fs_pkg::ACT_CONSOLE_DRAIN : uart_fs_pkg::ACT_CPU_READ;
            default:
                return uart_fs_pkg::action_t'($urandom_range(uart_fs_pkg::ACT_CPU_SEND,
                                                             uart_fs_pkg::ACT_STATUS));
        endcase
    endfunction

    // Offer one word after a drawn gap and hold it until accepted. Valid is
    // left high afterwards so that back-to-back words need no drop; stall is
    // sampled at the falling edge, where it is settled for the coming edge.
    task automatic send_word(input uart_fs_pkg::action_t act, input uart_fs_pkg::byte_t value);
        int gap;
        bit stalled;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        data_byte <= value;
        forever
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
            if (!stalled)
                break;
        end
        lsr_sb.note_word(act, value);
    endtask

    // Receiver: take result words, then stall for a drawn number of cycles.
    // A hold request stalls the output for a long stretch so the block backs
    // up and stalls its own input.
    initial
    begin
        int                            stall_left;
        bit                            got;
        bit                            hold_seen;
        lsr_scoreboard_pkg::lsr_word_t w;
        stall_left = 0;
        hold_seen  = 1'b0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            got = (out_valid === 1'b1) && !out_stall;
            w   = '{done_res, data_register, line_status, interrupt_request, console_valid};
            @(posedge clk);
            if (got)
            begin
                lsr_sb.check_word(w);
                stall_left = draw_gap();
            end
            if (hold_req && !hold_seen)
            begin
                stall_left = HOLD_CYCLES;
                hold_seen  = 1'b1;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Opening sequence: status toggling from reset, pops from empty FIFOs,
    // extreme bytes, status with each FIFO occupied, unused codes and a byte
    // on an action that ignores it.
    localparam int DIR_WORDS = 24;
    uart_fs_pkg::action_t dir_act[DIR_WORDS] = '{
        uart_fs_pkg::ACT_STATUS, uart_fs_pkg::ACT_STATUS,
        uart_fs_pkg::ACT_CPU_READ, uart_fs_pkg::ACT_CONSOLE_DRAIN,
        uart_fs_pkg::ACT_CPU_SEND, uart_fs_pkg::ACT_CPU_SEND,
        uart_fs_pkg::ACT_LINE_RECV, uart_fs_pkg::ACT_LINE_RECV,
        uart_fs_pkg::ACT_LINE_RECV, uart_fs_pkg::ACT_STATUS,
        uart_fs_pkg::ACT_STATUS, uart_fs_pkg::ACT_CONSOLE_DRAIN,
        uart_fs_pkg::ACT_CONSOLE_DRAIN, uart_fs_pkg::ACT_CONSOLE_DRAIN,
        uart_fs_pkg::ACT_STATUS, uart_fs_pkg::ACT_STATUS,
        uart_fs_pkg::ACT_CPU_READ, uart_fs_pkg::ACT_CPU_READ,
        uart_fs_pkg::ACT_CPU_READ, uart_fs_pkg::ACT_CPU_READ,
        lsr_scoreboard_pkg::ACT_UNUSED_LO,
        uart_fs_pkg::action_t'(lsr_scoreboard_pkg::ACT_UNUSED_LO + 3'd1),
        lsr_scoreboard_pkg::ACT_UNUSED_HI, uart_fs_pkg::ACT_STATUS
    };
    uart_fs_pkg::byte_t dir_byte[DIR_WORDS] = '{
        8'h00, 8'hFF, 8'h00, 8'h00,
        8'h00, 8'hFF, 8'hFF, 8'h00,
        8'hA5, 8'h00, 8'hFF, 8'hC3,
        8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5A,
        8'h5A, 8'hFF, 8'h00, 8'h3C
    };

    initial
    begin
        mix_e mix;
        int   seg;
        int   sent;
        lsr_sb      = new(FIFO_DEPTH);
        quiet       = 1'b0;
        hold_req    = 1'b0;
        in_valid    = 1'b0;
        action      = uart_fs_pkg::ACT_CPU_SEND;
        data_byte   = '0;
        rst_n       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_WORDS; i++)
            send_word(dir_act[i], dir_byte[i]);

        // Hold the output off and keep offering words back to back, so the
        // block fills up and has to stall its input.
        quiet    = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
            send_word(pick_action(MIX_ANY), draw_byte());

        // Random stretches: the first four visit each bias in turn so both
        // FIFOs reach full and empty early; later ones are drawn at random.
        sent = 0;
        seg  = 0;
        while (sent < RANDOM_WORDS)
        begin
            mix   = (seg < 4) ? mix_e'(seg) : mix_e'($urandom_range(0, 3));
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < SEG_WORDS; i++)
                send_word(pick_action(mix), draw_byte());
            sent += SEG_WORDS;
            seg++;
        end
        in_valid <= 1'b0;

        // Drain: wait for every expected word, then a few cycles more to
        // catch anything stray.
        while (lsr_sb.words_outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (lsr_sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
